// File: src/count_min_sketch_defines.svh
// ----------------------------------------------------------------------------
// count_min_sketch_defines
// Assertion macros shared by the count-min sketch RTL.
// ----------------------------------------------------------------------------
`ifndef COUNT_MIN_SKETCH_DEFINES_SVH
`define COUNT_MIN_SKETCH_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clk outside reset
`define CMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CMS_ASSERT_IMP(lbl, ante, cons, msg)
`define CMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared constants, types and helpers of the count-min sketch.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

  localparam int CMS_ROWS_DEF       = 4;
  localparam int CMS_LOG2_COLS_DEF  = 10;
  localparam int BUCKET_FIELDS      = 4;
  localparam int BUCKET_W           = 10;
  localparam int CNT_W              = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int LW_W       = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CONSERVATIVE = 1'b1;
  localparam logic [LW_W-1:0]      LOG2_WIDTH_RST   = 4'd10;

  // request codes
  localparam logic REQ_QUERY  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef struct packed {
    logic is_update;
    logic conservative;
  } upd_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: src/count_min_sketch.sv
// An accepted transaction is read from the row memories into their registered read
// data, then its estimate goes to the output register and an update is written back.
// No new transaction is taken meanwhile; a stalled output holding an earlier estimate
// keeps the block in its write-back step until taken. Reset: synchronous, active low;
// then a sweep zeroes all rows in parallel, taking no input but configuration writes.
// ----------------------------------------------------------------------------
// count_min_sketch
// Count-min frequency sketch, one memory per row, plain or conservative update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "count_min_sketch_defines.svh"

module count_min_sketch
  import cms_pkg::*;
#(
  parameter int ROWS         = CMS_ROWS_DEF,
  parameter int LOG2_COLUMNS = CMS_LOG2_COLS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // requests
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_req_type,
  input  wire logic [BUCKET_W-1:0]   in_bucket_row0,
  input  wire logic [BUCKET_W-1:0]   in_bucket_row1,
  input  wire logic [BUCKET_W-1:0]   in_bucket_row2,
  input  wire logic [BUCKET_W-1:0]   in_bucket_row3,
  // results
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CNT_W-1:0]           out_estimate
);

  localparam int ACT_ROWS = (ROWS < BUCKET_FIELDS) ? ROWS : BUCKET_FIELDS;
  localparam int COL_W    = LOG2_COLUMNS;
  localparam int DEPTH    = 1 << LOG2_COLUMNS;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [LW_W-1:0]   log2_width_r;
  logic              conservative_r;
  logic              is_update_r;
  logic [COL_W-1:0]  addr_r [ACT_ROWS];
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_estimate_r;

  logic [BUCKET_W-1:0] bucket [BUCKET_FIELDS];
  logic [COL_W-1:0]    col_mask;
  logic [COL_W-1:0]    col [ACT_ROWS];
  logic                in_fire;
  logic                wb_fire;
  logic                mem_we;
  logic [CNT_W-1:0]    rd_data [ACT_ROWS];
  logic [CNT_W-1:0]    wr_data [ACT_ROWS];
  logic [CNT_W-1:0]    estimate;
  upd_ctrl_t           upd_ctrl;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_width_r   <= LOG2_WIDTH_RST;
      conservative_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOG2_WIDTH:   log2_width_r   <= cfg_wdata[LW_W-1:0];
        REG_CONSERVATIVE: conservative_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // a width above the row size keeps every column bit, which is the clamp
  always_comb begin
    for (int i = 0; i < COL_W; i++) begin
      col_mask[i] = (int'(log2_width_r) > i);
    end
  end

  assign bucket[0] = in_bucket_row0;
  assign bucket[1] = in_bucket_row1;
  assign bucket[2] = in_bucket_row2;
  assign bucket[3] = in_bucket_row3;

  always_comb begin
    for (int r = 0; r < ACT_ROWS; r++) begin
      col[r] = COL_W'(bucket[r]) & col_mask;
    end
  end

  // ---------------------------------------------------------------- control
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign wb_fire  = (state_r == S_READ) && !(out_valid_r && out_stall);
  assign mem_we   = (state_r == S_CLEAR) || (wb_fire && is_update_r);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + COL_W'(1);
        if (clr_cnt_r == {COL_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (wb_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (wb_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_update_r <= (in_req_type == REQ_UPDATE);
      for (int r = 0; r < ACT_ROWS; r++) begin
        addr_r[r] <= col[r];
      end
    end
    if (wb_fire) begin
      out_estimate_r <= estimate;
    end
  end

  // ---------------------------------------------------------------- rows
  for (genvar r = 0; r < ACT_ROWS; r++) begin : g_row
    cms_ram #(
      .W     (CNT_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (mem_we),
      .waddr ((state_r == S_CLEAR) ? clr_cnt_r : addr_r[r]),
      .wdata ((state_r == S_CLEAR) ? {CNT_W{1'b0}} : wr_data[r]),
      .re    (in_fire),
      .raddr (col[r]),
      .rdata (rd_data[r])
    );
  end

  assign upd_ctrl.is_update    = is_update_r;
  assign upd_ctrl.conservative = conservative_r;

  cms_upd #(
    .N_ROWS (ACT_ROWS)
  ) u_upd (
    .ctrl     (upd_ctrl),
    .rd_data  (rd_data),
    .estimate (estimate),
    .wr_data  (wr_data)
  );

  assign out_valid    = out_valid_r;
  assign out_estimate = out_estimate_r;

  // ---------------------------------------------------------------- checks
  `CMS_ASSERT_NXT(a_accept_reads, in_fire, state_r == S_READ,
    "accepted transaction did not move to the read cycle")
  `CMS_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r,
    "result presented during the clearing sweep")
  `CMS_ASSERT_IMP(a_write_phase, mem_we, state_r != S_IDLE,
    "row memory written while idle")
  `CMS_ASSERT_NXT(a_update_nonzero, wb_fire && is_update_r, out_estimate_r != '0,
    "update returned a zero estimate")

endmodule

`default_nettype wire

// File: src/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/cms_upd.sv
// ----------------------------------------------------------------------------
// cms_upd
// Minimum over the row counters and the write-back values of an update.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_upd
  import cms_pkg::*;
#(
  parameter int N_ROWS = 4
) (
  input  wire upd_ctrl_t        ctrl,
  input  wire logic [CNT_W-1:0] rd_data  [N_ROWS],
  output logic      [CNT_W-1:0] estimate,
  output logic      [CNT_W-1:0] wr_data  [N_ROWS]
);

  logic [CNT_W-1:0] min_v;
  logic [CNT_W-1:0] target;

  always_comb begin
    min_v = CNT_MAX;
    for (int r = 0; r < N_ROWS; r++) begin
      if (rd_data[r] < min_v) begin
        min_v = rd_data[r];
      end
    end
  end

  assign target   = sat_inc(min_v);
  assign estimate = ctrl.is_update ? target : min_v;

  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      if (ctrl.conservative) begin
        wr_data[r] = (rd_data[r] > target) ? rd_data[r] : target;
      end else begin
        wr_data[r] = sat_inc(rd_data[r]);
      end
    end
  end

endmodule

`default_nettype wire
